/* rtl/core/edpg_pkg.sv */
// ----------------------------------------------------------------------------
// edpg_pkg: shared types and constants for the decay pulse generator
// Register map, pulse modes, reset values and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package edpg_pkg;

  localparam int unsigned BUFFER_BINS_DEFAULT = 16384;

  localparam int unsigned NUM_RESTARTS = 5;
  localparam int unsigned RESTART_W    = 15;
  localparam int unsigned RATIO_W      = 16;
  localparam int unsigned LEVEL_W      = 17;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned BIN_OUT_W    = 14;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_INDEX_W  = 3;

  localparam logic [LEVEL_W-1:0]   FULL_SCALE    = LEVEL_W'(32768);
  localparam logic [RESTART_W-1:0] RESTART_RESET = RESTART_W'(16384);
  localparam logic [RATIO_W-1:0]   RATIO_RESET   = RATIO_W'(65000);

  typedef enum logic [1:0] {
    MODE_SILENT = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_PAIR   = 2'd2,
    MODE_FULL   = 2'd3
  } pulse_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PULSE_MODE  = 3'd0,
    REG_RESTART_A   = 3'd1,
    REG_RESTART_B   = 3'd2,
    REG_RESTART_C   = 3'd3,
    REG_RESTART_D   = 3'd4,
    REG_RESTART_E   = 3'd5,
    REG_DECAY_RATIO = 3'd6
  } cfg_reg_t;

  typedef logic [NUM_RESTARTS-1:0][RESTART_W-1:0] restart_bins_t;

endpackage

`default_nettype wire

/* rtl/core/edpg_restart_match.sv */
// ----------------------------------------------------------------------------
// edpg_restart_match: restart detection
// Flags bin 0 and every restart bin that the current mode enables.
// ----------------------------------------------------------------------------
`default_nettype none

module edpg_restart_match #(
  parameter int unsigned CNT_W = 14
) (
  input  wire logic [CNT_W-1:0]            bin,
  input  wire edpg_pkg::pulse_mode_t       mode,
  input  wire edpg_pkg::restart_bins_t     restart_bins,
  output logic                             restart
);
  import edpg_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > RESTART_W) ? CNT_W : RESTART_W;

  logic [CMP_W-1:0]        bin_wide;
  logic [NUM_RESTARTS-1:0] hit;
  logic [NUM_RESTARTS-1:0] enable;

  assign bin_wide = CMP_W'(bin);

  always_comb begin
    for (int k = 0; k < NUM_RESTARTS; k++) begin
      hit[k] = (CMP_W'(restart_bins[k]) == bin_wide);
    end
  end

  always_comb begin
    unique case (mode)
      MODE_PAIR: enable = NUM_RESTARTS'(5'b00011);
      MODE_FULL: enable = NUM_RESTARTS'(5'b11111);
      default:   enable = '0;
    endcase
  end

  assign restart = (bin == '0) || ((hit & enable) != '0);

endmodule

`default_nettype wire

/* rtl/core/edpg_decay.sv */
// ----------------------------------------------------------------------------
// edpg_decay: level update
// Restarts the level at full scale or scales it by the Q0.16 decay ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module edpg_decay (
  input  wire logic [edpg_pkg::LEVEL_W-1:0] level,
  input  wire logic [edpg_pkg::RATIO_W-1:0] ratio,
  input  wire logic                         restart,
  output logic      [edpg_pkg::LEVEL_W-1:0] level_next
);
  import edpg_pkg::*;

  logic [LEVEL_W+RATIO_W-1:0] product;

  assign product    = (LEVEL_W+RATIO_W)'(level) * (LEVEL_W+RATIO_W)'(ratio);
  assign level_next = restart ? FULL_SCALE : product[LEVEL_W+RATIO_W-1:RATIO_W];

endmodule

`default_nettype wire

/* rtl/core/exp_decay_pulse_generator.sv */
// ----------------------------------------------------------------------------
// exp_decay_pulse_generator: exponential decay pulse train source
// Emits one buffer bin per input beat: bin index, negated decaying level in
// Q1.15 (zero in silent mode) and an end-of-buffer flag.
//
// Input channel: in_valid/in_ready with rewind; rewind 1 makes the beat
// bin 0, rewind 0 takes the next bin. Output channel: out_valid/out_ready
// with bin_index, sample and end_of_buffer, one result beat per input beat.
// Configuration: cfg_we/cfg_index/cfg_data write a register; the user must
// make writes only while no beat is in flight, as the block does not enforce it.
// Timing: the registered result beat appears in the cycle after the input is taken.
// Throughput: one beat per cycle while the output is not stalled; the level loop
// is one 17x16 multiply between the level register and itself.
// Reset: mode 1, restart bins 16384, ratio 65000, counter and level 0,
// output register empty.
// Stall: while out_ready is low the result is held and in_ready drops
// only when the output register is full and not being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module exp_decay_pulse_generator #(
  parameter int unsigned BUFFER_BINS = edpg_pkg::BUFFER_BINS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [edpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [edpg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                rewind,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [edpg_pkg::BIN_OUT_W-1:0]      bin_index,
  output logic signed [edpg_pkg::SAMPLE_W-1:0]     sample,
  output logic                                     end_of_buffer
);
  import edpg_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_BINS);
  localparam int unsigned OUT_W = (CNT_W > BIN_OUT_W) ? CNT_W : BIN_OUT_W;
  localparam logic [CNT_W-1:0] LAST_BIN = CNT_W'(BUFFER_BINS - 1);

  pulse_mode_t          pulse_mode;
  restart_bins_t        restart_bins;
  logic [RATIO_W-1:0]   decay_ratio;

  logic [CNT_W-1:0]     bin_counter;
  logic [LEVEL_W-1:0]   level_magnitude;

  logic [CNT_W-1:0]     bin;
  logic [OUT_W-1:0]     bin_wide;
  logic                 restart;
  logic [LEVEL_W-1:0]   level_next;
  logic [LEVEL_W-1:0]   level_neg;
  logic                 accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_mode   <= MODE_SINGLE;
      restart_bins <= {NUM_RESTARTS{RESTART_RESET}};
      decay_ratio  <= RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PULSE_MODE:  pulse_mode      <= pulse_mode_t'(cfg_data[1:0]);
        REG_RESTART_A:   restart_bins[0] <= cfg_data[RESTART_W-1:0];
        REG_RESTART_B:   restart_bins[1] <= cfg_data[RESTART_W-1:0];
        REG_RESTART_C:   restart_bins[2] <= cfg_data[RESTART_W-1:0];
        REG_RESTART_D:   restart_bins[3] <= cfg_data[RESTART_W-1:0];
        REG_RESTART_E:   restart_bins[4] <= cfg_data[RESTART_W-1:0];
        REG_DECAY_RATIO: decay_ratio     <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign bin      = rewind ? '0 : bin_counter;
  assign bin_wide = OUT_W'(bin);

  edpg_restart_match #(
    .CNT_W(CNT_W)
  ) u_match (
    .bin          (bin),
    .mode         (pulse_mode),
    .restart_bins (restart_bins),
    .restart      (restart)
  );

  edpg_decay u_decay (
    .level      (level_magnitude),
    .ratio      (decay_ratio),
    .restart    (restart),
    .level_next (level_next)
  );

  assign level_neg = LEVEL_W'(0) - level_next;

  // bin and level state
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter     <= '0;
      level_magnitude <= '0;
    end else if (accept) begin
      bin_counter     <= (bin == LAST_BIN) ? '0 : bin + CNT_W'(1);
      level_magnitude <= level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin_index     <= bin_wide[BIN_OUT_W-1:0];
      sample        <= (pulse_mode == MODE_SILENT) ? '0 : level_neg[SAMPLE_W-1:0];
      end_of_buffer <= (bin == LAST_BIN);
    end
  end

endmodule

`default_nettype wire

/* dv/edpg_checker.sv */
// ----------------------------------------------------------------------------
// edpg_checker: result predictor and comparator for the decay pulse generator
// Tracks register writes, predicts one result beat for every input beat
// taken and compares each result beat, field by field, with the oldest
// prediction. Reports the mismatch count and the predictions still waiting.
// ----------------------------------------------------------------------------
module edpg_checker
  import edpg_pkg::*;
#(
  parameter int unsigned BINS = BUFFER_BINS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      rewind,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [BIN_OUT_W-1:0]      bin_index,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                      end_of_buffer,
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct packed {
    logic [BIN_OUT_W-1:0] bin;
    logic [SAMPLE_W-1:0]  sample;
    logic                 eob;
  } pulse_beat_t;

  pulse_mode_t          mode;
  logic [RESTART_W-1:0] restart_at [NUM_RESTARTS];
  logic [RATIO_W-1:0]   ratio;
  int unsigned          next_bin;
  logic [LEVEL_W-1:0]   level;
  pulse_beat_t          pending_pulses [$];

  function automatic logic hits_restart(input int unsigned bin);
    int unsigned enabled;
    if (bin == 0) return 1'b1;
    enabled = 0;
    if (mode == MODE_PAIR) enabled = 2;
    else if (mode == MODE_FULL) enabled = NUM_RESTARTS;
    for (int k = 0; k < enabled; k++)
      if (bin == restart_at[k]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic pulse_beat_t emit_pulse(input logic rw);
    int unsigned                  bin;
    logic [LEVEL_W+RATIO_W-1:0]   product;
    logic [LEVEL_W-1:0]           negated;
    pulse_beat_t                  beat;
    bin = rw ? 0 : next_bin;
    if (bin >= BINS) bin = 0;
    if (hits_restart(bin)) begin
      level = FULL_SCALE;
    end else begin
      product = level * ratio;
      level = product[RATIO_W +: LEVEL_W];
    end
    negated = -level;
    beat.bin = bin[BIN_OUT_W-1:0];
    beat.sample = (mode == MODE_SILENT) ? '0 : negated[SAMPLE_W-1:0];
    beat.eob = (bin == BINS - 1);
    next_bin = (bin + 1 >= BINS) ? 0 : bin + 1;
    return beat;
  endfunction

  always @(posedge clk) begin : watch
    pulse_beat_t want;
    if (rst) begin
      mode = MODE_SINGLE;
      for (int k = 0; k < NUM_RESTARTS; k++) restart_at[k] = RESTART_RESET;
      ratio = RATIO_RESET;
      next_bin = 0;
      level = '0;
      mismatches = 0;
      pending_pulses.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pulses.size() == 0) begin
          mismatches++;
          $error("result beat with none expected: bin_index %0d sample %0d",
                 bin_index, sample);
        end else begin
          want = pending_pulses.pop_front();
          if (bin_index !== want.bin) begin
            mismatches++;
            $error("bin_index expected %0d actual %0d", want.bin, bin_index);
          end
          if (sample !== $signed(want.sample)) begin
            mismatches++;
            $error("sample expected %0d actual %0d", $signed(want.sample), sample);
          end
          if (end_of_buffer !== want.eob) begin
            mismatches++;
            $error("end_of_buffer expected %0d actual %0d", want.eob, end_of_buffer);
          end
        end
      end
      if (in_valid && in_ready) pending_pulses.push_back(emit_pulse(rewind));
      if (cfg_we) begin
        case (cfg_index)
          REG_PULSE_MODE: mode = pulse_mode_t'(cfg_data[1:0]);
          REG_RESTART_A, REG_RESTART_B, REG_RESTART_C, REG_RESTART_D,
          REG_RESTART_E: restart_at[cfg_index - REG_RESTART_A] = cfg_data[RESTART_W-1:0];
          REG_DECAY_RATIO: ratio = cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = pending_pulses.size();
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: regression bench for the exponential decay pulse generator
// Directed passes over every pulse mode and register corner, one long pass
// with a stretch of no idling and a long output stall, then random phases
// with random register settings, random rewinds, random idling on both
// sides and a long output stall. Checking is done by edpg_checker.
// ----------------------------------------------------------------------------
module tb;
  import edpg_pkg::*;

  localparam int unsigned BINS = BUFFER_BINS_DEFAULT;
  localparam logic [CFG_INDEX_W-1:0] UNMAPPED_REG = 3'd7;
  localparam int CYCLE_LIMIT = 40000;
  localparam int LONG_HOLD   = 400;
  localparam int SWEEP_BEATS   = 500;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS   = 100;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       rewind = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [BIN_OUT_W-1:0]       bin_index;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       end_of_buffer;
  int                         mismatches;
  int                         outstanding;
  int                         cycle_count = 0;
  int                         idle_pct = 15;
  bit                         hold_request = 1'b0;

  exp_decay_pulse_generator #(.BUFFER_BINS(BINS)) dut (.*);

  edpg_checker #(.BINS(BINS)) u_checker (.*);

  always #4 clk = ~clk;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // output side: random backpressure plus long hold-offs on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic offer_tick(input logic rw);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rewind <= rw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pass(input int count);
    offer_tick(1'b1);
    for (int i = 1; i < count; i++) offer_tick(1'b0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_restart();
    int r;
    r = $urandom_range(9);
    if (r < 6) return CFG_DATA_W'($urandom_range(250, 1));
    if (r == 6) return '0;
    if (r == 7) return CFG_DATA_W'(BINS - 1);
    if (r == 8) return CFG_DATA_W'(BINS);
    return CFG_DATA_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_ratio();
    int r;
    r = $urandom_range(9);
    if (r < 6) return CFG_DATA_W'($urandom_range(65535, 50000));
    if (r == 6) return '0;
    if (r == 7) return 16'hFFFF;
    return CFG_DATA_W'($urandom);
  endfunction

  task automatic shuffle_config();
    if ($urandom_range(7) == 0) write_reg(REG_PULSE_MODE, CFG_DATA_W'($urandom));
    else write_reg(REG_PULSE_MODE, CFG_DATA_W'($urandom_range(3)));
    for (int k = 0; k < NUM_RESTARTS; k++)
      write_reg(CFG_INDEX_W'(REG_RESTART_A + k), pick_restart());
    write_reg(REG_DECAY_RATIO, pick_ratio());
    if ($urandom_range(4) == 0) write_reg(UNMAPPED_REG, CFG_DATA_W'($urandom));
  endtask

  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: single pulse, then a rewind in mid pass
    send_pass(5);
    send_pass(3);
    settle();

    // silent mode
    write_reg(REG_PULSE_MODE, CFG_DATA_W'(MODE_SILENT));
    send_pass(3);
    settle();

    // full mode: equal, unordered, unreachable and too-wide restarts, zero ratio
    write_reg(REG_PULSE_MODE, CFG_DATA_W'(MODE_FULL));
    write_reg(REG_RESTART_A, 16'd2);
    write_reg(REG_RESTART_B, 16'd2);
    write_reg(REG_RESTART_C, 16'd1);
    write_reg(REG_RESTART_D, CFG_DATA_W'(BINS));
    write_reg(REG_RESTART_E, 16'hFFFF);
    write_reg(REG_DECAY_RATIO, 16'd0);
    write_reg(UNMAPPED_REG, 16'hFFFF);
    send_pass(5);
    settle();

    // too-wide mode value, largest ratio
    write_reg(REG_PULSE_MODE, 16'hFFFE);
    write_reg(REG_DECAY_RATIO, 16'hFFFF);
    send_pass(4);
    settle();

    // long pass: a stretch with no idling and a long output stall
    write_reg(REG_PULSE_MODE, CFG_DATA_W'(MODE_FULL));
    write_reg(REG_RESTART_A, 16'd100);
    write_reg(REG_RESTART_B, CFG_DATA_W'(BINS - 1));
    write_reg(REG_RESTART_C, 16'd300);
    write_reg(REG_RESTART_D, 16'd0);
    write_reg(REG_RESTART_E, CFG_DATA_W'(BINS));
    write_reg(REG_DECAY_RATIO, 16'd65300);
    offer_tick(1'b1);
    for (int i = 0; i < SWEEP_BEATS; i++) begin
      if (i == 100) idle_pct = 0;
      if (i == 300) idle_pct = 15;
      if (i == 350) hold_request = 1'b1;
      offer_tick(1'b0);
    end
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      shuffle_config();
      idle_pct = (p == 3) ? 0 : 15;
      if (p == 6) hold_request = 1'b1;
      offer_tick($urandom_range(3) != 0);
      for (int i = 1; i < PHASE_BEATS; i++) offer_tick($urandom_range(39) == 0);
      settle();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/core/edpg_pkg.sv
rtl/core/edpg_restart_match.sv
rtl/core/edpg_decay.sv
rtl/core/exp_decay_pulse_generator.sv
dv/edpg_checker.sv
dv/tb.sv
